[rtl/core/c3gf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3gf_pkg: shared types and constants of the 3x3 grayscale filter
// Sizes, configuration register codes, reset values and the stage record
// passed from the window stage to the filter datapath.
// ----------------------------------------------------------------------------
package c3gf_pkg;

    // Frame geometry
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_SIZE     = 3;
    localparam int KSIZE        = 3;

    // Field widths
    localparam int PIX_W        = 8;
    localparam int PIX_MAX      = 255;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT) + 1;  // holds H+1 while draining
    localparam int OUT_ROW_W    = 12;
    localparam int OUT_COL_W    = 10;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;

    // Kernel coefficients, signed fixed point
    localparam int COEF_W          = 16;
    localparam int KROW_W          = KSIZE * COEF_W;
    localparam int COEFF_FRAC_BITS = 11;
    localparam int PROD_W          = PIX_W + 1 + COEF_W;
    localparam int ACC_W           = PROD_W + 4;

    // Line store word: both buffered rows at one column
    localparam int LINE_W       = 2 * PIX_W;

    // Configuration port
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = KROW_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET   = 11'd512;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET  = 13'd512;
    localparam logic [KROW_W-1:0]       KROW_ZERO     = 48'h0000_0000_0000;
    localparam logic [KROW_W-1:0]       KROW_MID_RESET = 48'h0000_0800_0000;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // 3x3 neighborhood, [row][col], row 0 on top, col 0 on the left
    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;

    // Three packed kernel rows, left coefficient in the low bits
    typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;

    // Per-result record carried down the filter pipeline
    typedef struct packed {
        logic                 use_filt;
        logic [PIX_W-1:0]     copy_px;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } meta_t;

endpackage

[rtl/core/c3gf_line_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3gf_line_mem: two-row line store
// One word per column holds the two buffered rows. Synchronous, registered
// read; a write to the address being read is forwarded.
// ----------------------------------------------------------------------------
module c3gf_line_mem
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [c3gf_pkg::COL_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [c3gf_pkg::COL_W-1:0] wr_addr,
    input  logic [c3gf_pkg::LINE_W-1:0] wr_data,
    output logic [c3gf_pkg::LINE_W-1:0] rd_data
);
    import c3gf_pkg::*;

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;
    logic [LINE_W-1:0] byp_data_reg;
    logic              byp_valid_reg;
    logic              byp_valid_next;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // Flag a read that collides with the write of the same cycle
    assign byp_valid_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= byp_valid_next;
        end
    end

    assign rd_data = byp_valid_reg ? byp_data_reg : rd_data_reg;

endmodule

[rtl/core/c3gf_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3gf_filter: multiply, accumulate, round and clamp
// Three stages: nine products, their sum, then rounding into the output
// register. Border pixels ride along and take their copied value.
// ----------------------------------------------------------------------------
module c3gf_filter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  c3gf_pkg::window_t             win,
    input  c3gf_pkg::kernel_t             kernel,
    input  c3gf_pkg::meta_t               meta_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [c3gf_pkg::PIX_W-1:0]    pixel_out,
    output logic [c3gf_pkg::OUT_ROW_W-1:0] out_row,
    output logic [c3gf_pkg::OUT_COL_W-1:0] out_col,
    output logic                          frame_last
);
    import c3gf_pkg::*;

    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] SAT_MAX = ACC_W'(PIX_MAX);

    logic [KSIZE-1:0][KSIZE-1:0][PROD_W-1:0] prod_reg;
    logic [KSIZE-1:0][KSIZE-1:0][PROD_W-1:0] prod_next;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] rnd_sum;
    logic [ACC_W-1:0] rnd_val;
    logic [PIX_W-1:0] filt_px;
    meta_t            meta2_reg;
    meta_t            meta3_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             out_valid_reg;
    logic             adv2;
    logic             adv3;
    logic             adv4;
    logic [PIX_W-1:0] pixel_out_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic             frame_last_reg;

    // Advance each stage when it is empty or its successor moves
    assign adv4     = !out_valid_reg || !out_stall;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign in_ready = adv2;

    // Nine products of pixel and signed coefficient
    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                prod_next[i][j] = PROD_W'($signed({1'b0, win[i][j]})
                                * $signed(kernel[i][COEF_W*j +: COEF_W]));
            end
        end
    end

    // Sum the products
    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                acc_next = acc_next + ACC_W'($signed(prod_reg[i][j]));
            end
        end
    end

    // Round half up on a non-negative sum, clamp to the pixel range
    always_comb
    begin
        rnd_sum = acc_reg + HALF;
        rnd_val = rnd_sum >> COEFF_FRAC_BITS;
        if (acc_reg[ACC_W-1])
        begin
            filt_px = '0;
        end
        else if (rnd_val > SAT_MAX)
        begin
            filt_px = PIX_W'(PIX_MAX);
        end
        else
        begin
            filt_px = rnd_val[PIX_W-1:0];
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
            begin
                v2_reg <= in_valid;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            prod_reg  <= prod_next;
            meta2_reg <= meta_in;
        end
        if (adv3)
        begin
            acc_reg   <= acc_next;
            meta3_reg <= meta2_reg;
        end
        if (adv4)
        begin
            pixel_out_reg  <= meta3_reg.use_filt ? filt_px : meta3_reg.copy_px;
            out_row_reg    <= meta3_reg.row;
            out_col_reg    <= meta3_reg.col;
            frame_last_reg <= meta3_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

endmodule

[rtl/core/conv3x3_gray_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_gray_filter: 3x3 convolution over a raster grayscale stream
// Line store, sliding window and a pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, cmd, pixel_in) takes one pixel per
//   clock while in_stall is low, in raster order. The result for pixel (r,c) belongs to the item
//   W+1 positions later, so after the last pixel of a frame send W+1 flush
//   items (cmd = flush) to drain it; a flush inside a frame is taken and
//   dropped. Output channel (out_valid/out_stall) gives pixel_out with its
//   out_row, out_col and frame_last on pixel (H-1, W-1).
//   Throughput is one item per clock while nothing stalls, set by the line
//   store: one read and one write of its single port pair per item. A result
//   reaches out_valid through the window, product, sum and rounding
//   registers after the item that completes it is transferred.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wr_data) land on the
//   next edge; issue them only while the block is idle.
//   Reset clears counters, window and pipeline; registers return to a
//   512x512 frame with the identity kernel. The line store is not cleared.
//   When the receiver stalls, the output register holds and the pipeline
//   fills its bubbles; in_stall rises once all stages hold results.
// ----------------------------------------------------------------------------
module conv3x3_gray_filter
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [c3gf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [c3gf_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [c3gf_pkg::PIX_W-1:0]       pixel_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [c3gf_pkg::PIX_W-1:0]       pixel_out,
    output logic [c3gf_pkg::OUT_ROW_W-1:0]   out_row,
    output logic [c3gf_pkg::OUT_COL_W-1:0]   out_col,
    output logic                             frame_last
);
    import c3gf_pkg::*;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    kernel_t                 kernel_reg;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    window_t          win_reg;
    window_t          win_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    meta_t            s1_meta_reg;
    meta_t            s1_meta_next;

    logic             filt_ready;
    logic             accept;
    logic             draining;
    logic             step;
    logic [PIX_W-1:0] val;
    logic [LINE_W-1:0] rd_word;
    logic [LINE_W-1:0] wr_word;
    logic             wr_en;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    logic             col_nz;
    logic             emit;
    logic             is_last;
    logic             interior;
    logic             col_wrap;
    logic [ROW_W-1:0] r_out;
    logic [COL_W-1:0] c_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            kernel_reg[0] <= KROW_ZERO;
            kernel_reg[1] <= KROW_MID_RESET;
            kernel_reg[2] <= KROW_ZERO;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg     <= cfg_wr_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg    <= cfg_wr_data[HEIGHT_REG_W-1:0];
                CFG_KERNEL_TOP:    kernel_reg[0] <= cfg_wr_data[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: kernel_reg[1] <= cfg_wr_data[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_wr_data[KROW_W-1:0];
                default:           ;
            endcase
        end
    end

    // Saturate the frame size to the supported range
    always_comb
    begin
        if (width_reg < WIDTH_REG_W'(MIN_SIZE))
        begin
            w_eff = WIDTH_REG_W'(MIN_SIZE);
        end
        else if (width_reg > WIDTH_REG_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end

        if (height_reg < HEIGHT_REG_W'(MIN_SIZE))
        begin
            h_eff = HEIGHT_REG_W'(MIN_SIZE);
        end
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
        begin
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // Input handshake: the window stage waits while its result cannot move on
    assign in_stall = s1_valid_reg && !filt_ready;
    assign accept   = in_valid && !in_stall;
    assign draining = ROW_W'(row_reg) >= ROW_W'(h_eff);
    assign step     = accept && (draining || (cmd == CMD_PIXEL));
    assign val      = draining ? '0 : pixel_in;

    // Split the line store word into the two buffered rows
    assign top_px  = row_reg[0] ? rd_word[LINE_W-1:PIX_W] : rd_word[PIX_W-1:0];
    assign mid_px  = row_reg[0] ? rd_word[PIX_W-1:0] : rd_word[LINE_W-1:PIX_W];
    assign wr_word = row_reg[0] ? {val, rd_word[PIX_W-1:0]}
                                : {rd_word[LINE_W-1:PIX_W], val};
    assign wr_en   = step && !draining;

    // Output position and classification of the emitted pixel
    always_comb
    begin
        col_nz = (col_reg != '0);
        emit   = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && col_nz);
        r_out  = col_nz ? row_reg - ROW_W'(1) : row_reg - ROW_W'(2);
        c_out  = col_nz ? col_reg - COL_W'(1) : COL_W'(w_eff - WIDTH_REG_W'(1));

        is_last = ((ROW_W+1)'(r_out) + (ROW_W+1)'(1) >= (ROW_W+1)'(h_eff))
               && (WIDTH_REG_W'(c_out) + WIDTH_REG_W'(1) >= w_eff);

        interior = col_nz
                && (r_out != '0)
                && ((ROW_W+1)'(r_out) + (ROW_W+1)'(2) <= (ROW_W+1)'(h_eff))
                && (c_out != '0)
                && (WIDTH_REG_W'(c_out) + WIDTH_REG_W'(2) <= w_eff);

        col_wrap = (WIDTH_REG_W'(col_reg) + WIDTH_REG_W'(1) >= w_eff);
    end

    // Advance the raster counters; restart at the end of a frame
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (step)
        begin
            if (emit && is_last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_wrap)
            begin
                row_next = row_reg + ROW_W'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Shift the window by one column; clear it at the end of a frame
    always_comb
    begin
        win_next = win_reg;
        if (step)
        begin
            if (emit && is_last)
            begin
                win_next = '0;
            end
            else
            begin
                for (int k = 0; k < KSIZE; k++)
                begin
                    win_next[k][0] = win_reg[k][1];
                    win_next[k][1] = win_reg[k][2];
                end
                win_next[0][2] = top_px;
                win_next[1][2] = mid_px;
                win_next[2][2] = val;
            end
        end
    end

    // Load the window stage record
    always_comb
    begin
        s1_valid_next         = step ? emit : (s1_valid_reg && !filt_ready);
        s1_meta_next.use_filt = interior;
        s1_meta_next.copy_px  = win_reg[1][2];
        s1_meta_next.row      = r_out[OUT_ROW_W-1:0];
        s1_meta_next.col      = c_out[OUT_COL_W-1:0];
        s1_meta_next.last     = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            win_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            win_reg      <= win_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_meta_reg <= s1_meta_next;
        end
    end

    // Line store: prefetch the column of the next item
    c3gf_line_mem u_line_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (col_next),
        .wr_en   (wr_en),
        .wr_addr (col_reg),
        .wr_data (wr_word),
        .rd_data (rd_word)
    );

    // Multiply-accumulate pipeline and output register
    c3gf_filter u_filter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_ready   (filt_ready),
        .win        (win_reg),
        .kernel     (kernel_reg),
        .meta_in    (s1_meta_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

endmodule

[rtl/core/c3gf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3gf_checker: port-level checks of the 3x3 grayscale filter
// Output and input handshake, pipeline depth after reset, and frame start position.
// ----------------------------------------------------------------------------
module c3gf_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [c3gf_pkg::PIX_W-1:0]       pixel_out,
    input logic [c3gf_pkg::OUT_ROW_W-1:0]   out_row,
    input logic [c3gf_pkg::OUT_COL_W-1:0]   out_col,
    input logic                             frame_last
);
    import c3gf_pkg::*;

    logic frame_start_reg;
    logic out_xfer;
    logic in_xfer;

    assign out_xfer = out_valid && !out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // Track whether the next output opens a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            frame_start_reg <= frame_last;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled output dropped valid");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_out) && $stable(out_row)
                                   && $stable(out_col) && $stable(frame_last))
        else $error("stalled output payload changed");

    // The window, product, sum and output registers stand between reset and the first result
    a_reset_depth: assert property (@(posedge clk)
        !rst_n |=> !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("output valid too soon after reset");

    // Every frame starts at the top left pixel
    a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start_reg |-> (out_row == '0) && (out_col == '0))
        else $error("frame does not start at row 0, column 0");

    // An input transfer never happens while the input is stalled
    a_no_xfer_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !in_stall)
        else $error("input transfer during stall");

endmodule

bind conv3x3_gray_filter c3gf_checker u_c3gf_checker (.*);

[tb/tb_conv3x3_gray_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_gray_filter: self-checking bench for the 3x3 grayscale filter
// Streams raster frames with flush ticks into the filter and keeps its own
// model of line store, window, counters and registers. Each transfer on
// the output channel is compared field by field with the oldest predicted
// pixel. Covers the reset kernel, kernel extremes, rounding ties, flush
// handling, frame size saturation, size changes inside a frame and long
// output back-pressure, then random frames under several idling mixes.
// ----------------------------------------------------------------------------
module tb_conv3x3_gray_filter;

    import c3gf_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESULT_LATENCY = 3;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_ITEMS   = 120;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [COEF_W-1:0] COEF_ZERO  = 16'h0000;
    localparam logic [COEF_W-1:0] COEF_ONE   = 16'h0800;
    localparam logic [COEF_W-1:0] COEF_HALF  = 16'h0400;
    localparam logic [COEF_W-1:0] COEF_3HALF = 16'h0C00;
    localparam logic [COEF_W-1:0] COEF_NINTH = 16'h00E4;
    localparam logic [COEF_W-1:0] COEF_MAX   = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_MIN   = 16'h8000;

    typedef enum int { PAT_NOISE, PAT_EXTREME, PAT_ODD } pixel_pattern_t;

    typedef struct packed {
        logic [PIX_W-1:0]     px;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } pixel_result_t;

    // DUT connections
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   cmd;
    logic [PIX_W-1:0]       pixel_in;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PIX_W-1:0]       pixel_out;
    logic [OUT_ROW_W-1:0]   out_row;
    logic [OUT_COL_W-1:0]   out_col;
    logic                   frame_last;

    // Filter model state
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [KROW_W-1:0]       kernel_reg [0:KSIZE-1];
    logic [PIX_W-1:0]        line_mem [0:2*MAX_WIDTH-1];
    logic [PIX_W-1:0]        nbhd [0:KSIZE-1][0:KSIZE-1];
    int unsigned             row_pos;
    int unsigned             col_pos;

    // Checking state
    pixel_result_t expected_pixels[$];
    pixel_result_t step_res;
    pixel_result_t oldest;
    bit            step_made;
    bit            in_fire;
    int            mismatch_count;
    int unsigned   cycle_count;
    int unsigned   pixel_count;

    // Idling controls
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;

    conv3x3_gray_filter i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .frame_last  (frame_last)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------------
    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w < MIN_SIZE) w = MIN_SIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = height_reg;
        if (h < MIN_SIZE) h = MIN_SIZE;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // Advance the model by one accepted item; report the pixel it releases
    function automatic void convolve_step(input logic is_flush, input logic [PIX_W-1:0] pix,
                                          output bit produced, output pixel_result_t res);
        int unsigned w, h, r_in, c_in, cidx, top_addr, mid_addr, r_out, c_out;
        int i, j;
        bit draining, last;
        logic [PIX_W-1:0] val, centre_prev, top_px, mid_px;
        longint acc, rounded, half;
        produced = 1'b0;
        res = '0;
        w = eff_width();
        h = eff_height();
        r_in = row_pos;
        c_in = col_pos;
        draining = (r_in >= h);

        // Drop a flush while the frame is still taking pixels
        if (!draining && is_flush)
            return;
        val = draining ? '0 : pix;
        cidx = c_in % MAX_WIDTH;
        top_addr = (r_in & 1) * MAX_WIDTH + cidx;
        mid_addr = ((r_in + 1) & 1) * MAX_WIDTH + cidx;

        // Shift the window left and load the new column
        centre_prev = nbhd[1][2];
        top_px = line_mem[top_addr];
        mid_px = line_mem[mid_addr];
        for (i = 0; i < KSIZE; i++)
        begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = top_px;
        nbhd[1][2] = mid_px;
        nbhd[2][2] = val;
        if (!draining)
            line_mem[top_addr] = val;

        if (c_in >= 1)
        begin
            r_out = r_in - 1;
            c_out = c_in - 1;
        end
        else
        begin
            r_out = r_in - 2;
            c_out = w - 1;
        end

        // Advance input position, wrapping at the current width
        if (c_in + 1 >= w)
        begin
            col_pos = 0;
            row_pos = r_in + 1;
        end
        else
            col_pos = c_in + 1;

        if (!((r_in >= 2) || (r_in == 1 && c_in >= 1)))
            return;

        // Copy border pixels, filter the interior
        if (c_in == 0)
            res.px = centre_prev;
        else if (r_out >= 1 && r_out + 2 <= h && c_out >= 1 && c_out + 2 <= w)
        begin
            acc = 0;
            for (i = 0; i < KSIZE; i++)
                for (j = 0; j < KSIZE; j++)
                    acc += longint'(nbhd[i][j])
                           * longint'($signed(kernel_reg[i][COEF_W*j +: COEF_W]));
            half = longint'(1) << (COEFF_FRAC_BITS - 1);
            if (acc >= 0)
                rounded = (acc + half) >>> COEFF_FRAC_BITS;
            else
                rounded = -((half - acc) >>> COEFF_FRAC_BITS);
            if (rounded < 0) rounded = 0;
            if (rounded > PIX_MAX) rounded = PIX_MAX;
            res.px = rounded[PIX_W-1:0];
        end
        else
            res.px = nbhd[1][1];

        last = (r_out + 1 >= h) && (c_out + 1 >= w);
        res.row = r_out[OUT_ROW_W-1:0];
        res.col = c_out[OUT_COL_W-1:0];
        res.last = last;
        produced = 1'b1;

        // Restart counters and window after the final pixel
        if (last)
        begin
            row_pos = 0;
            col_pos = 0;
            for (i = 0; i < KSIZE; i++)
                for (j = 0; j < KSIZE; j++)
                    nbhd[i][j] = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on input transfers, check output transfers
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            in_fire = rst_n && in_valid && !in_stall;
            if (in_fire)
            begin
                convolve_step(cmd, pixel_in, step_made, step_res);
                if (step_made)
                    expected_pixels.push_back(step_res);
            end
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected pixel: px=%0d row=%0d col=%0d last=%0b",
                                 pixel_out, out_row, out_col, frame_last);
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (oldest.px !== pixel_out || oldest.row !== out_row ||
                        oldest.col !== out_col || oldest.last !== frame_last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("pixel mismatch: expected px=%0d row=%0d col=%0d last=%0b,",
                                     oldest.px, oldest.row, oldest.col, oldest.last,
                                     " got px=%0d row=%0d col=%0d last=%0b",
                                     pixel_out, out_row, out_col, frame_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off while hold_left counts down
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall = (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers, all entered and left just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(input logic item_cmd, input logic [PIX_W-1:0] item_px);
        // Insert idle cycles, then offer the item until it transfers
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            cmd      = 1'($urandom);
            pixel_in = 8'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd      = item_cmd;
        pixel_in = item_px;
        do
            @(negedge clk);
        while (!in_fire);
        if (item_cmd == CMD_PIXEL)
            pixel_count++;
    endtask

    task automatic settle();
        // Hold the input until every predicted pixel is out and the pipe is empty
        in_valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        case (idx)
            CFG_IMAGE_WIDTH:   width_reg     = data[WIDTH_REG_W-1:0];
            CFG_IMAGE_HEIGHT:  height_reg    = data[HEIGHT_REG_W-1:0];
            CFG_KERNEL_TOP:    kernel_reg[0] = data;
            CFG_KERNEL_MIDDLE: kernel_reg[1] = data;
            CFG_KERNEL_BOTTOM: kernel_reg[2] = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic set_kernel(input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
                              input logic [KROW_W-1:0] bot);
        write_reg(CFG_KERNEL_TOP, top);
        write_reg(CFG_KERNEL_MIDDLE, mid);
        write_reg(CFG_KERNEL_BOTTOM, bot);
    endtask

    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [KROW_W-1:0] krow(input logic [COEF_W-1:0] left,
                                               input logic [COEF_W-1:0] centre,
                                               input logic [COEF_W-1:0] right);
        return {right, centre, left};
    endfunction

    function automatic logic [KROW_W-1:0] random_krow();
        logic [KROW_W-1:0] row;
        logic [COEF_W-1:0] coef;
        int j;
        for (j = 0; j < KSIZE; j++)
        begin
            case ($urandom_range(7))
                0:       coef = 16'($urandom);
                1:       coef = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                default: coef = 16'($urandom_range(1400)) - 16'd400;
            endcase
            row[COEF_W*j +: COEF_W] = coef;
        end
        return row;
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(input pixel_pattern_t pat);
        case (pat)
            PAT_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            PAT_ODD:     return 8'($urandom_range(255)) | 8'h01;
            default:     return 8'($urandom_range(255));
        endcase
    endfunction

    // Stream one frame; noise adds in-frame flushes and pixels during the drain
    task automatic send_frame(input pixel_pattern_t pat, input int unsigned noise_pct,
                              input int unsigned drain_cut);
        int unsigned n_pix, n_drain, k;
        n_pix = eff_width() * eff_height();
        n_drain = eff_width() + 1 - drain_cut;
        for (k = 0; k < n_pix; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(CMD_FLUSH, 8'($urandom));
            send_item(CMD_PIXEL, next_pixel(pat));
        end
        for (k = 0; k < n_drain; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(CMD_PIXEL, 8'($urandom));
            else
                send_item(CMD_FLUSH, 8'($urandom));
        end
    endtask

    // Feed a mix of pixels and flushes until the model is back at frame start
    task automatic finish_frame();
        while (row_pos != 0 || col_pos != 0)
        begin
            if (row_pos >= eff_height())
                send_item($urandom_range(1) ? CMD_FLUSH : CMD_PIXEL, 8'($urandom));
            else
                send_item($urandom_range(3) != 0 ? CMD_PIXEL : CMD_FLUSH, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_kernel();
        // Identity kernel from reset passes every pixel through
        set_idle(0, 0);
        set_frame(4, 3);
        send_frame(PAT_EXTREME, 0, 0);
        send_frame(PAT_NOISE, 0, 0);
        settle();
    endtask

    task automatic test_kernel_extremes();
        set_idle(55, 0);
        set_frame(5, 4);
        set_kernel(krow(COEF_MAX, COEF_MAX, COEF_MAX), krow(COEF_MAX, COEF_MAX, COEF_MAX),
                   krow(COEF_MAX, COEF_MAX, COEF_MAX));
        send_frame(PAT_NOISE, 0, 0);
        settle();
        set_kernel(krow(COEF_MIN, COEF_MIN, COEF_MIN), krow(COEF_MIN, COEF_MIN, COEF_MIN),
                   krow(COEF_MIN, COEF_MIN, COEF_MIN));
        send_frame(PAT_EXTREME, 0, 0);
        settle();
        set_kernel(krow(COEF_MAX, COEF_ZERO, COEF_MAX), krow(COEF_ZERO, COEF_ONE, COEF_ZERO),
                   krow(COEF_MIN, COEF_ZERO, COEF_MIN));
        send_frame(PAT_EXTREME, 0, 0);
        settle();
    endtask

    task automatic test_rounding_ties();
        // Odd pixels times one half or three halves land exactly on .5
        set_idle(0, 55);
        set_frame(6, 4);
        set_kernel(krow(COEF_ZERO, COEF_ZERO, COEF_ZERO), krow(COEF_ZERO, COEF_HALF, COEF_ZERO),
                   krow(COEF_ZERO, COEF_ZERO, COEF_ZERO));
        send_frame(PAT_ODD, 0, 0);
        settle();
        set_kernel(krow(COEF_ZERO, COEF_ZERO, COEF_ZERO), krow(COEF_ZERO, COEF_3HALF, COEF_ZERO),
                   krow(COEF_ZERO, -COEF_HALF, COEF_ZERO));
        send_frame(PAT_ODD, 0, 0);
        settle();
    endtask

    task automatic test_flush_handling();
        // Flushes inside the frame are dropped, pixels in the drain act as flushes
        set_idle(19, 19);
        set_frame(4, 4);
        set_kernel(krow(COEF_NINTH, COEF_NINTH, COEF_NINTH),
                   krow(COEF_NINTH, COEF_NINTH, COEF_NINTH),
                   krow(COEF_NINTH, COEF_NINTH, COEF_NINTH));
        send_frame(PAT_NOISE, 30, 0);
        send_frame(PAT_NOISE, 100, 0);
        settle();
    endtask

    task automatic test_size_saturation();
        int k;
        set_idle(0, 0);
        set_frame(0, 0);
        send_frame(PAT_NOISE, 0, 0);
        settle();
        set_frame(2, 1);
        send_frame(PAT_EXTREME, 0, 0);
        settle();
        // Clamp oversized registers to the largest frame, then close it small
        set_frame(2047, 8191);
        for (k = 0; k < 12; k++)
            send_item(CMD_PIXEL, 8'($urandom));
        settle();
        set_frame(4, 3);
        finish_frame();
        settle();
    endtask

    task automatic test_size_change_mid_frame();
        int k;
        set_idle(0, 0);
        // Narrow the frame in the middle of its third row
        set_frame(8, 6);
        for (k = 0; k < 20; k++)
            send_item(CMD_PIXEL, 8'($urandom));
        settle();
        set_frame(5, 4);
        finish_frame();
        settle();
        // Shrink below the current row so the next item closes the frame
        set_frame(8, 6);
        for (k = 0; k < 30; k++)
            send_item(CMD_PIXEL, 8'($urandom));
        settle();
        set_frame(4, 3);
        finish_frame();
        settle();
    endtask

    task automatic test_output_hold();
        // Hold the receiver off while a whole frame is offered
        set_idle(0, 0);
        set_frame(10, 10);
        in_valid = 1'b0;
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
        send_frame(PAT_NOISE, 0, 0);
        settle();
    endtask

    task automatic test_random_frames();
        int mode;
        int unsigned start_count;
        pixel_pattern_t pat;
        for (mode = 0; mode < 4; mode++)
        begin
            settle();
            case (mode)
                0:       set_idle(0, 0);
                1:       set_idle(55, 0);
                2:       set_idle(0, 55);
                default: set_idle(19, 19);
            endcase
            start_count = pixel_count;
            while (pixel_count - start_count < RANDOM_ITEMS / 4)
            begin
                // Reconfigure between frames now and then
                if ($urandom_range(1) != 0)
                begin
                    settle();
                    set_frame($urandom_range(3, 8), $urandom_range(3, 5));
                    set_kernel(random_krow(), random_krow(), random_krow());
                end
                pat = pixel_pattern_t'($urandom_range(2));
                case ($urandom_range(9))
                    0, 1:
                    begin
                        send_frame(pat, 20, $urandom_range(1, eff_width()));
                        finish_frame();
                    end
                    2:       send_frame(pat, 10, 0);
                    default: send_frame(pat, 0, 0);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_IMAGE_WIDTH;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        cmd            = CMD_PIXEL;
        pixel_in       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        pixel_count    = 0;
        hold_left      = 0;
        set_idle(0, 0);

        // Model registers and state at reset
        width_reg     = WIDTH_RESET;
        height_reg    = HEIGHT_RESET;
        kernel_reg[0] = KROW_ZERO;
        kernel_reg[1] = KROW_MID_RESET;
        kernel_reg[2] = KROW_ZERO;
        for (int a = 0; a < 2 * MAX_WIDTH; a++)
            line_mem[a] = '0;
        for (int i = 0; i < KSIZE; i++)
            for (int j = 0; j < KSIZE; j++)
                nbhd[i][j] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_kernel();
        test_kernel_extremes();
        test_rounding_ties();
        test_flush_handling();
        test_size_saturation();
        test_size_change_mid_frame();
        test_output_hold();
        test_random_frames();

        set_idle(0, 0);
        settle();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/c3gf_pkg.sv
rtl/core/c3gf_line_mem.sv
rtl/core/c3gf_filter.sv
rtl/core/conv3x3_gray_filter.sv
rtl/core/c3gf_checker.sv
tb/tb_conv3x3_gray_filter.sv
